>>> sv/tcis_pkg.sv
// Shared constants, codes and types of the teaching CPU instruction step unit.
// No dependencies; every other file in this folder refers to it by scoped name.
package tcis_pkg;

    localparam int XLEN      = 32;
    localparam int MEM_WORDS = 256;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int REG_COUNT = 8;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int ADDR_W    = 8;
    localparam int OP_W      = 24;
    localparam int RCR_SHORT = 34;   // longest count run step by step as given
    localparam int RCR_BASE  = 32;   // after this many steps the rotate repeats every 3
    localparam int CNT_W     = 6;

    typedef enum logic [2:0] {
        ST_RUN        = 3'd0,
        ST_HALT       = 3'd1,
        ST_PC_RANGE   = 3'd2,
        ST_ADDR_RANGE = 3'd3,
        ST_ILLEGAL    = 3'd4,
        ST_DIV_ZERO   = 3'd5
    } status_t;

    localparam logic [1:0] FN_LOAD   = 2'd0;
    localparam logic [1:0] FN_EXEC   = 2'd1;
    localparam logic [1:0] FN_RD_REG = 2'd2;
    localparam logic [1:0] FN_RD_MEM = 2'd3;

    localparam logic [OP_W-1:0] OP_ADD  = 24'd0;
    localparam logic [OP_W-1:0] OP_NAND = 24'd1;
    localparam logic [OP_W-1:0] OP_LW   = 24'd2;
    localparam logic [OP_W-1:0] OP_SW   = 24'd3;
    localparam logic [OP_W-1:0] OP_BEQ  = 24'd4;
    localparam logic [OP_W-1:0] OP_JALR = 24'd5;
    localparam logic [OP_W-1:0] OP_HALT = 24'd6;
    localparam logic [OP_W-1:0] OP_NOOP = 24'd7;
    localparam logic [OP_W-1:0] OP_DIV  = 24'd8;
    localparam logic [OP_W-1:0] OP_XIDIV = 24'd9;
    localparam logic [OP_W-1:0] OP_XADD = 24'd10;
    localparam logic [OP_W-1:0] OP_AND  = 24'd11;
    localparam logic [OP_W-1:0] OP_XOR  = 24'd12;
    localparam logic [OP_W-1:0] OP_CMPL = 24'd13;
    localparam logic [OP_W-1:0] OP_JMAE = 24'd14;
    localparam logic [OP_W-1:0] OP_JMLE = 24'd15;
    localparam logic [OP_W-1:0] OP_SBB  = 24'd16;
    localparam logic [OP_W-1:0] OP_BT   = 24'd17;
    localparam logic [OP_W-1:0] OP_RCR  = 24'd18;
    localparam logic [OP_W-1:0] OP_LWB  = 24'd19;
    localparam logic [OP_W-1:0] OP_DIVB = 24'd20;
    localparam logic [OP_W-1:0] OP_XORB = 24'd21;
    localparam logic [OP_W-1:0] OP_ANDB = 24'd22;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // residue of one hex digit modulo 3
    function automatic logic [1:0] nib_mod3(input logic [3:0] nib);
        logic [1:0] r;
        case (nib)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
            default:                              r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

>>> sv/tcis_req_if.sv
// Request channel of the instruction step unit: valid, ready and one item.
// Depends on tcis_pkg for field widths.
interface tcis_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    func;
    logic [tcis_pkg::ADDR_W-1:0]   address;
    logic signed [tcis_pkg::XLEN-1:0] data;

    modport source (output valid, func, address, data, input ready);
    modport sink   (input valid, func, address, data, output ready);
endinterface

>>> sv/tcis_rsp_if.sv
// Result channel of the instruction step unit: valid, ready and one result.
// Depends on tcis_pkg for field widths.
interface tcis_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [2:0]                       status;
    logic signed [tcis_pkg::XLEN-1:0] next_pc;
    logic                             carry_flag;
    logic signed [tcis_pkg::XLEN-1:0] read_data;

    modport source (output valid, status, next_pc, carry_flag, read_data, input ready);
    modport sink   (input valid, status, next_pc, carry_flag, read_data, output ready);
endinterface

>>> sv/tcis_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on tcis_pkg for XLEN and div_stat_t.
module tcis_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tcis_pkg::XLEN-1:0] dividend,
    input  logic [tcis_pkg::XLEN-1:0] divisor,
    output tcis_pkg::div_stat_t       stat,
    output logic [tcis_pkg::XLEN-1:0] quotient
);
    localparam int CW = $clog2(tcis_pkg::XLEN + 1);

    logic [CW-1:0]              cnt_reg;
    logic                       done_reg;
    logic [tcis_pkg::XLEN:0]    rem_reg;
    logic [tcis_pkg::XLEN-1:0]  quo_reg;
    logic [tcis_pkg::XLEN-1:0]  dsr_reg;
    logic [tcis_pkg::XLEN:0]    rem_shift;
    logic [tcis_pkg::XLEN:0]    rem_sub;

    assign rem_shift = {rem_reg[tcis_pkg::XLEN-1:0], quo_reg[tcis_pkg::XLEN-1]};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                cnt_reg <= CW'(tcis_pkg::XLEN);
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (!rem_sub[tcis_pkg::XLEN])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[tcis_pkg::XLEN-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[tcis_pkg::XLEN-2:0], 1'b0};
            end
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
endmodule

>>> sv/teaching_cpu_instruction_step_unit.sv
// Instruction step unit of the teaching CPU: memory, register file and sequencer.
// Depends on tcis_pkg, tcis_req_if, tcis_rsp_if and tcis_divider.
//
//   channel | direction | beat
//   req     | in        | func, address, data
//   rsp     | out       | status, next_pc, carry_flag, read_data
//
// One item at a time. Load and register read go straight to the result register;
// memory read waits on the registered memory port; an instruction is fetched through
// that port, then executed, and lw reads memory once more; div, xidiv and divb wait on
// the divider; rcr steps once per count, with the modulo-3 count reduction above 34.
// Reset clears the memory valid bits, registers, pc, carry, base and status at once.
// A waiting result does not stop the next beat; a second result holds until the first is taken.
module teaching_cpu_instruction_step_unit (
    input logic         clk,
    input logic         rst_n,
    tcis_req_if.sink    req,
    tcis_rsp_if.source  rsp
);
    localparam int XL = tcis_pkg::XLEN;
    localparam int AW = tcis_pkg::MEM_AW;
    localparam int CW = tcis_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_MREAD, S_FETCH, S_EXEC, S_LWAIT, S_DIV, S_RMOD, S_RCR, S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [XL-1:0]             pc_reg, pc_next;
    logic                      carry_reg, carry_next;
    logic [1:0]                base_reg, base_next;
    tcis_pkg::status_t         mstat_reg, mstat_next;
    logic [XL-1:0]             rf_reg [tcis_pkg::REG_COUNT];
    logic [XL-1:0]             rf_next [tcis_pkg::REG_COUNT];
    logic [XL-1:0]             ir_reg, ir_next;
    logic [XL-1:0]             rdata_reg, rdata_next;
    logic [XL-1:0]             rot_reg, rot_next;
    logic [XL-1:0]             xm_reg, xm_next;
    logic [1:0]                acc_reg, acc_next;
    logic [2:0]                nib_reg, nib_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      dneg_reg, dneg_next;

    logic [XL-1:0]             mem [tcis_pkg::MEM_WORDS];
    logic                      mvalid_reg [tcis_pkg::MEM_WORDS];
    logic [XL-1:0]             mem_q_reg;
    logic                      mem_qv_reg;
    logic                      mem_re, mem_we;
    logic [AW-1:0]             mem_ra, mem_wa;
    logic [XL-1:0]             mem_wd;
    logic [XL-1:0]             word;

    logic                      out_valid_reg;
    logic [2:0]                out_status_reg;
    logic [XL-1:0]             out_pc_reg, out_rdata_reg;
    logic                      out_carry_reg;

    logic                      wb_en, wb_swap;
    logic [tcis_pkg::REG_AW-1:0] wb_idx;
    logic [XL-1:0]             wb_val, swap_tmp;

    logic                      div_start;
    logic [XL-1:0]             div_a, div_b, div_q, q_signed;
    tcis_pkg::div_stat_t       div_stat;

    logic [tcis_pkg::OP_W-1:0] op;
    logic [1:0]                ra, rb;
    logic [2:0]                rd;
    logic [3:0]                off;
    logic [XL-1:0]             a, b, tb, dsr, pc_inc, rot_step;
    logic [XL:0]               ea;
    logic                      ea_bad;
    logic [2:0]                acc_sum;

    assign word     = mem_qv_reg ? mem_q_reg : '0;
    assign op       = ir_reg[XL-1:8];
    assign ra       = ir_reg[7:6];
    assign rb       = ir_reg[5:4];
    assign rd       = ir_reg[2:0];
    assign off      = ir_reg[3:0];
    assign a        = rf_reg[{1'b0, ra}];
    assign b        = rf_reg[{1'b0, rb}];
    assign tb       = rf_reg[{1'b0, base_reg}];
    assign dsr      = (op == tcis_pkg::OP_DIVB) ? tb : b;
    assign pc_inc   = pc_reg + 1'b1;
    assign ea       = {a[XL-1], a} + {{(XL-3){1'b0}}, off};
    assign ea_bad   = ea[XL] || (ea[XL-1:0] >= XL'(tcis_pkg::MEM_WORDS));
    assign div_a    = a[XL-1] ? (~a + 1'b1) : a;
    assign div_b    = dsr[XL-1] ? (~dsr + 1'b1) : dsr;
    assign q_signed = dneg_reg ? (~div_q + 1'b1) : div_q;
    assign rot_step = {rot_reg[XL-1], rot_reg[XL-1:1]} | {29'b0, rot_reg[0], 2'b0};
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, tcis_pkg::nib_mod3(xm_reg[3:0])};

    assign req.ready = (state_reg == S_IDLE);

    tcis_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .stat     (div_stat),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        carry_next = carry_reg;
        base_next  = base_reg;
        mstat_next = mstat_reg;
        ir_next    = ir_reg;
        rdata_next = rdata_reg;
        rot_next   = rot_reg;
        xm_next    = xm_reg;
        acc_next   = acc_reg;
        nib_next   = nib_reg;
        cnt_next   = cnt_reg;
        dneg_next  = dneg_reg;
        mem_re     = 1'b0;
        mem_ra     = pc_reg[AW-1:0];
        mem_we     = 1'b0;
        mem_wa     = req.address[AW-1:0];
        mem_wd     = req.data;
        div_start  = 1'b0;
        wb_en      = 1'b0;
        wb_swap    = 1'b0;
        wb_idx     = rd;
        wb_val     = '0;
        swap_tmp   = '0;
        for (int i = 0; i < tcis_pkg::REG_COUNT; i++)
            rf_next[i] = rf_reg[i];

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rdata_next = '0;
                    state_next = S_DONE;
                    case (req.func)
                        tcis_pkg::FN_LOAD:
                            mem_we = 1'b1;
                        tcis_pkg::FN_EXEC:
                        begin
                            if (mstat_reg != tcis_pkg::ST_RUN)
                                state_next = S_DONE;
                            else if (pc_reg >= XL'(tcis_pkg::MEM_WORDS))
                                mstat_next = tcis_pkg::ST_PC_RANGE;
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_FETCH;
                            end
                        end
                        tcis_pkg::FN_RD_REG:
                        begin
                            if (req.address < tcis_pkg::ADDR_W'(tcis_pkg::REG_COUNT))
                                rdata_next = rf_reg[req.address[tcis_pkg::REG_AW-1:0]];
                        end
                        default:
                        begin
                            mem_re     = 1'b1;
                            mem_ra     = req.address[AW-1:0];
                            state_next = S_MREAD;
                        end
                    endcase
                end
            end

            S_MREAD:
            begin
                rdata_next = word;
                state_next = S_DONE;
            end

            S_FETCH:
            begin
                ir_next    = word;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                pc_next    = pc_inc;
                state_next = S_DONE;
                case (op)
                    tcis_pkg::OP_ADD,
                    tcis_pkg::OP_NAND,
                    tcis_pkg::OP_AND,
                    tcis_pkg::OP_XOR,
                    tcis_pkg::OP_CMPL,
                    tcis_pkg::OP_SBB:
                    begin
                        wb_en = 1'b1;
                        case (op)
                            tcis_pkg::OP_ADD:  wb_val = a + b;
                            tcis_pkg::OP_NAND: wb_val = ~(a & b);
                            tcis_pkg::OP_AND:  wb_val = a & b;
                            tcis_pkg::OP_XOR:  wb_val = a ^ b;
                            tcis_pkg::OP_CMPL: wb_val = {31'b0, $signed(a) < $signed(b)};
                            default:           wb_val = a - b - {31'b0, carry_reg};
                        endcase
                    end
                    tcis_pkg::OP_LW:
                    begin
                        if (ea_bad)
                            mstat_next = tcis_pkg::ST_ADDR_RANGE;
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_ra     = ea[AW-1:0];
                            state_next = S_LWAIT;
                        end
                    end
                    tcis_pkg::OP_SW:
                    begin
                        if (ea_bad)
                            mstat_next = tcis_pkg::ST_ADDR_RANGE;
                        else
                        begin
                            mem_we = 1'b1;
                            mem_wa = ea[AW-1:0];
                            mem_wd = b;
                        end
                    end
                    tcis_pkg::OP_BEQ:
                        if (a == b)
                            pc_next = pc_inc + {28'b0, off};
                    tcis_pkg::OP_JMAE:
                        if ($signed(a) >= $signed(b))
                            pc_next = pc_inc + {28'b0, off};
                    tcis_pkg::OP_JMLE:
                        if ($signed(a) <= $signed(b))
                            pc_next = pc_inc + {28'b0, off};
                    tcis_pkg::OP_JALR:
                    begin
                        wb_en  = 1'b1;
                        wb_idx = {1'b0, rb};
                        wb_val = pc_inc;
                        // target reads A after the link write
                        if (ra == 2'd0)
                            pc_next = '0;
                        else if (ra == rb)
                            pc_next = pc_inc;
                        else
                            pc_next = a;
                    end
                    tcis_pkg::OP_HALT:
                        mstat_next = tcis_pkg::ST_HALT;
                    tcis_pkg::OP_NOOP:
                        state_next = S_DONE;
                    tcis_pkg::OP_DIV,
                    tcis_pkg::OP_XIDIV,
                    tcis_pkg::OP_DIVB:
                    begin
                        if (dsr == '0)
                            mstat_next = tcis_pkg::ST_DIV_ZERO;
                        else
                        begin
                            div_start  = 1'b1;
                            dneg_next  = a[XL-1] ^ dsr[XL-1];
                            state_next = S_DIV;
                        end
                    end
                    tcis_pkg::OP_XADD:
                    begin
                        wb_en   = 1'b1;
                        wb_val  = a + b;
                        wb_swap = 1'b1;
                    end
                    tcis_pkg::OP_BT:
                        carry_next = a[b[4:0]];
                    tcis_pkg::OP_RCR:
                    begin
                        rot_next = a;
                        if ($signed(b) <= 0)
                        begin
                            wb_en  = 1'b1;
                            wb_val = a;
                        end
                        else if ($signed(b) <= tcis_pkg::RCR_SHORT)
                        begin
                            cnt_next   = b[CW-1:0];
                            state_next = S_RCR;
                        end
                        else
                        begin
                            xm_next    = b - XL'(tcis_pkg::RCR_BASE);
                            acc_next   = 2'd0;
                            nib_next   = 3'd0;
                            state_next = S_RMOD;
                        end
                    end
                    tcis_pkg::OP_LWB:
                        base_next = ra;
                    tcis_pkg::OP_XORB:
                    begin
                        wb_en  = 1'b1;
                        wb_idx = {1'b0, rb};
                        wb_val = a ^ tb;
                    end
                    tcis_pkg::OP_ANDB:
                    begin
                        wb_en  = 1'b1;
                        wb_idx = {1'b0, rb};
                        wb_val = a & tb;
                    end
                    default:
                        mstat_next = tcis_pkg::ST_ILLEGAL;
                endcase
            end

            S_LWAIT:
            begin
                wb_en      = 1'b1;
                wb_idx     = {1'b0, rb};
                wb_val     = word;
                state_next = S_DONE;
            end

            S_DIV:
            begin
                if (div_stat.done)
                begin
                    wb_en      = 1'b1;
                    state_next = S_DONE;
                    case (op)
                        tcis_pkg::OP_DIV:
                            wb_val = div_q[XL-1] ? (~div_q + 1'b1) : div_q;
                        tcis_pkg::OP_XIDIV:
                        begin
                            wb_val  = q_signed;
                            wb_swap = 1'b1;
                        end
                        default:
                        begin
                            wb_idx = {1'b0, rb};
                            wb_val = q_signed;
                        end
                    endcase
                end
            end

            S_RMOD:
            begin
                // fold one hex digit per cycle: 16 is 1 modulo 3
                acc_next = (acc_sum >= 3'd3) ? 2'(acc_sum - 3'd3) : acc_sum[1:0];
                xm_next  = xm_reg >> 4;
                nib_next = nib_reg + 1'b1;
                if (nib_reg == 3'd7)
                begin
                    cnt_next   = CW'(tcis_pkg::RCR_BASE) +
                                 CW'((acc_sum >= 3'd3) ? 2'(acc_sum - 3'd3) : acc_sum[1:0]);
                    state_next = S_RCR;
                end
            end

            S_RCR:
            begin
                rot_next   = rot_step;
                carry_next = rot_reg[0];
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    wb_en      = 1'b1;
                    wb_val     = rot_step;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase

        if (wb_en)
            rf_next[wb_idx] = wb_val;
        if (wb_swap)
        begin
            swap_tmp          = rf_next[{1'b0, ra}];
            rf_next[{1'b0, ra}] = rf_next[{1'b0, rb}];
            rf_next[{1'b0, rb}] = swap_tmp;
        end
        rf_next[0] = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            carry_reg <= 1'b0;
            base_reg  <= '0;
            mstat_reg <= tcis_pkg::ST_RUN;
            for (int i = 0; i < tcis_pkg::REG_COUNT; i++)
                rf_reg[i] <= '0;
            for (int i = 0; i < tcis_pkg::MEM_WORDS; i++)
                mvalid_reg[i] <= 1'b0;
            cnt_reg       <= '0;
            nib_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            carry_reg <= carry_next;
            base_reg  <= base_next;
            mstat_reg <= mstat_next;
            for (int i = 0; i < tcis_pkg::REG_COUNT; i++)
                rf_reg[i] <= rf_next[i];
            if (mem_we)
                mvalid_reg[mem_wa] <= 1'b1;
            cnt_reg <= cnt_next;
            nib_reg <= nib_next;
            if (state_reg == S_DONE && (!out_valid_reg || rsp.ready))
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ir_reg    <= ir_next;
        rdata_reg <= rdata_next;
        rot_reg   <= rot_next;
        xm_reg    <= xm_next;
        acc_reg   <= acc_next;
        dneg_reg  <= dneg_next;
        if (state_reg == S_DONE && (!out_valid_reg || rsp.ready))
        begin
            out_status_reg <= mstat_reg;
            out_pc_reg     <= pc_reg;
            out_carry_reg  <= carry_reg;
            out_rdata_reg  <= rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
        begin
            mem_q_reg  <= mem[mem_ra];
            mem_qv_reg <= mvalid_reg[mem_ra];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.next_pc    = out_pc_reg;
    assign rsp.carry_flag = out_carry_reg;
    assign rsp.read_data  = out_rdata_reg;
endmodule

>>> sv/tcis_checker.sv
// Port-level checks of the instruction step unit, attached by bind.
// Depends on the top level's req and rsp interface ports.
module tcis_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status
);
    logic [1:0] pending_reg;
    logic       stopped_reg;
    logic       in_beat, out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, in_beat} - {1'b0, out_beat};
            if (out_beat && status != tcis_pkg::ST_RUN)
                stopped_reg <= 1'b1;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result without an accepted beat");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two beats in flight");

    a_sticky_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stopped_reg |-> status != tcis_pkg::ST_RUN)
        else $error("stopped machine reported running");
endmodule

bind teaching_cpu_instruction_step_unit tcis_checker u_tcis_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (rsp.status)
);

>>> sim/testbench.sv
// Self-checking testbench of teaching_cpu_instruction_step_unit: directed rows, then
// random instruction streams checked against a behavioral copy of the machine.
// Depends on tcis_pkg, tcis_req_if, tcis_rsp_if and the unit itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 3000;
    localparam int RAND_ITEMS = 1420;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] pc;
        logic        carry;
        logic [31:0] rdata;
    } outcome_t;

    typedef struct {
        logic [1:0]  func;
        logic [7:0]  address;
        logic [31:0] data;
        logic        lit_en;
        outcome_t    lit;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tcis_req_if req_ch();
    tcis_rsp_if rsp_ch();

    teaching_cpu_instruction_step_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // machine copy
    logic [31:0] cpu_pc;
    logic [31:0] cpu_regs [tcis_pkg::REG_COUNT];
    logic [31:0] cpu_mem [tcis_pkg::MEM_WORDS];
    logic        cpu_carry;
    logic [1:0]  cpu_base;
    tcis_pkg::status_t cpu_status;

    outcome_t pending_q[$];
    stim_row_t rows[$];
    int  n_mismatch = 0;
    int  n_items = 0;
    int  n_exec = 0;
    int  n_checked = 0;
    int  op_seen [23];
    bit  idle_on = 1'b1;
    int  rsp_hold = 0;
    bit  stim_done = 1'b0;
    bit  hold_done = 1'b0;
    bit  pause_done = 1'b0;

    function automatic logic [31:0] magn(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [31:0] quot(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] q;
        q = magn(a) / magn(b);
        if (a[31] ^ b[31])
            q = 32'd0 - q;
        return q;
    endfunction

    function automatic logic [31:0] instr(input logic [tcis_pkg::OP_W-1:0] op,
                                          input logic [1:0] a, input logic [1:0] b,
                                          input logic [3:0] low);
        return {op, a, b, low};
    endfunction

    function automatic tcis_pkg::status_t run_instr();
        logic [31:0] w, a, b, t, r;
        logic [tcis_pkg::OP_W-1:0] op;
        int ra, rb, rd;
        logic [3:0] off;
        longint ea, n;
        logic lsb;
        if (cpu_pc >= tcis_pkg::MEM_WORDS)
            return tcis_pkg::ST_PC_RANGE;
        w = cpu_mem[cpu_pc[7:0]];
        op = w[31:8];
        ra = int'(w[7:6]);
        rb = int'(w[5:4]);
        rd = int'(w[2:0]);
        off = w[3:0];
        cpu_pc = cpu_pc + 32'd1;
        if (op > tcis_pkg::OP_ANDB)
            return tcis_pkg::ST_ILLEGAL;
        op_seen[op]++;
        a = cpu_regs[ra];
        b = cpu_regs[rb];
        case (op)
            tcis_pkg::OP_ADD:  cpu_regs[rd] = a + b;
            tcis_pkg::OP_NAND: cpu_regs[rd] = ~(a & b);
            tcis_pkg::OP_LW, tcis_pkg::OP_SW:
            begin
                ea = longint'($signed(a)) + longint'(off);
                if (ea < 0 || ea >= tcis_pkg::MEM_WORDS)
                    return tcis_pkg::ST_ADDR_RANGE;
                if (op == tcis_pkg::OP_LW)
                    cpu_regs[rb] = cpu_mem[ea];
                else
                    cpu_mem[ea] = b;
            end
            tcis_pkg::OP_BEQ:  if (a == b) cpu_pc = cpu_pc + {28'd0, off};
            tcis_pkg::OP_JALR:
            begin
                cpu_regs[rb] = cpu_pc;
                cpu_pc = (ra != 0) ? cpu_regs[ra] : 32'd0;
            end
            tcis_pkg::OP_HALT: return tcis_pkg::ST_HALT;
            tcis_pkg::OP_NOOP: ;
            tcis_pkg::OP_DIV:
            begin
                if (b == 0)
                    return tcis_pkg::ST_DIV_ZERO;
                cpu_regs[rd] = magn(quot(a, b));
            end
            tcis_pkg::OP_XIDIV, tcis_pkg::OP_XADD:
            begin
                if (op == tcis_pkg::OP_XIDIV)
                begin
                    if (b == 0)
                        return tcis_pkg::ST_DIV_ZERO;
                    cpu_regs[rd] = quot(a, b);
                end
                else
                    cpu_regs[rd] = a + b;
                t = cpu_regs[ra];
                cpu_regs[ra] = cpu_regs[rb];
                cpu_regs[rb] = t;
            end
            tcis_pkg::OP_AND:  cpu_regs[rd] = a & b;
            tcis_pkg::OP_XOR:  cpu_regs[rd] = a ^ b;
            tcis_pkg::OP_CMPL: cpu_regs[rd] = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            tcis_pkg::OP_JMAE: if ($signed(a) >= $signed(b)) cpu_pc = cpu_pc + {28'd0, off};
            tcis_pkg::OP_JMLE: if ($signed(a) <= $signed(b)) cpu_pc = cpu_pc + {28'd0, off};
            tcis_pkg::OP_SBB:  cpu_regs[rd] = a - b - {31'd0, cpu_carry};
            tcis_pkg::OP_BT:   cpu_carry = a[b[4:0]];
            tcis_pkg::OP_RCR:
            begin
                n = longint'($signed(b));
                r = a;
                // the rotate repeats every three steps once past 32
                if (n > 34)
                    n = 32 + (n - 32) % 3;
                while (n > 0)
                begin
                    lsb = r[0];
                    r = {r[31], r[31:1]};
                    cpu_carry = lsb;
                    if (lsb)
                        r[2] = 1'b1;
                    n--;
                end
                cpu_regs[rd] = r;
            end
            tcis_pkg::OP_LWB:  cpu_base = w[7:6];
            tcis_pkg::OP_DIVB:
            begin
                t = cpu_regs[cpu_base];
                if (t == 0)
                    return tcis_pkg::ST_DIV_ZERO;
                cpu_regs[rb] = quot(a, t);
            end
            tcis_pkg::OP_XORB: cpu_regs[rb] = a ^ cpu_regs[cpu_base];
            default: cpu_regs[rb] = a & cpu_regs[cpu_base];
        endcase
        cpu_regs[0] = 32'd0;
        return tcis_pkg::ST_RUN;
    endfunction

    function automatic outcome_t step_machine(input logic [1:0] f, input logic [7:0] ad,
                                              input logic [31:0] d);
        outcome_t o;
        logic [31:0] rd;
        rd = 32'd0;
        case (f)
            tcis_pkg::FN_LOAD:   cpu_mem[ad] = d;
            tcis_pkg::FN_EXEC:
            begin
                n_exec++;
                if (cpu_status == tcis_pkg::ST_RUN)
                    cpu_status = run_instr();
            end
            tcis_pkg::FN_RD_REG: if (ad < tcis_pkg::REG_COUNT) rd = cpu_regs[ad[2:0]];
            default:   rd = cpu_mem[ad];
        endcase
        o.status = cpu_status;
        o.pc = cpu_pc;
        o.carry = cpu_carry;
        o.rdata = rd;
        return o;
    endfunction

    // build an instruction that keeps the machine running at the current pc
    function automatic logic [31:0] safe_instr();
        logic [tcis_pkg::OP_W-1:0] op;
        logic [1:0] a, b;
        logic [3:0] low;
        logic [31:0] va, vb;
        longint ea;
        op = tcis_pkg::OP_W'($urandom_range(0, 22));
        if (op == tcis_pkg::OP_HALT)
            op = tcis_pkg::OP_NOOP;
        a = 2'($urandom);
        b = 2'($urandom);
        low = 4'($urandom);
        va = cpu_regs[a];
        vb = cpu_regs[b];
        if (cpu_pc > 235)
        begin
            op = tcis_pkg::OP_JALR;
            a = 2'd0;
        end
        case (op)
            tcis_pkg::OP_LW, tcis_pkg::OP_SW:
            begin
                ea = longint'($signed(va)) + longint'(low);
                if (ea < 0 || ea >= tcis_pkg::MEM_WORDS)
                    a = 2'd0;
            end
            tcis_pkg::OP_JALR:
                if (a != 0 && a != b && va >= 32'd236)
                    a = 2'd0;
            tcis_pkg::OP_DIV, tcis_pkg::OP_XIDIV: if (vb == 0) op = tcis_pkg::OP_ADD;
            tcis_pkg::OP_DIVB: if (cpu_regs[cpu_base] == 0) op = tcis_pkg::OP_XOR;
            default: ;
        endcase
        return instr(op, a, b, low);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 40);
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] f, input logic [7:0] ad, input logic [31:0] d,
                             input logic lit_en, input outcome_t lit);
        outcome_t o;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.func = f;
        req_ch.address = ad;
        req_ch.data = d;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        o = step_machine(f, ad, d);
        pending_q.push_back(lit_en ? lit : o);
        n_items++;
        @(negedge clk);
    endtask

    task automatic send(input logic [1:0] f, input logic [7:0] ad, input logic [31:0] d);
        send_item(f, ad, d, 1'b0, '0);
    endtask

    task automatic exec_word(input logic [31:0] w);
        send(tcis_pkg::FN_LOAD, cpu_pc[7:0], w);
        send(tcis_pkg::FN_EXEC, 8'($urandom), $urandom);
    endtask

    task automatic add_row(input logic [1:0] f, input logic [7:0] ad, input logic [31:0] d,
                           input logic lit_en, input outcome_t lit);
        stim_row_t r;
        r.func = f;
        r.address = ad;
        r.data = d;
        r.lit_en = lit_en;
        r.lit = lit;
        rows.push_back(r);
    endtask

    // result side: ready bursts, plus one long hold
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold > 0)
            begin
                rsp_ch.ready = 1'b0;
                rsp_hold--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end
            else
                rsp_ch.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("tb: unexpected beat status=%0d pc=%h", rsp_ch.status,
                             rsp_ch.next_pc);
            end
            else
            begin
                e = pending_q.pop_front();
                n_checked++;
                if (rsp_ch.status !== e.status || rsp_ch.next_pc !== e.pc ||
                    rsp_ch.carry_flag !== e.carry || rsp_ch.read_data !== e.rdata)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"tb: beat %0d exp st=%0d pc=%h c=%b rd=%h ",
                                  "got st=%0d pc=%h c=%b rd=%h"},
                                 n_checked, e.status, e.pc, e.carry, e.rdata, rsp_ch.status,
                                 rsp_ch.next_pc, rsp_ch.carry_flag, rsp_ch.read_data);
                end
            end
        end
    end

    int quiet = 0;
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n ||
            (stim_done && pending_q.size() == 0))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG)
        begin
            $display("tb: stalled for %0d cycles, %0d beats outstanding", quiet,
                     pending_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        outcome_t z;
        int k;
        logic [31:0] w;
        req_ch.valid = 1'b0;
        req_ch.func = tcis_pkg::FN_RD_REG;
        req_ch.address = '0;
        req_ch.data = '0;
        cpu_pc = '0;
        cpu_carry = 1'b0;
        cpu_base = '0;
        cpu_status = tcis_pkg::ST_RUN;
        for (int i = 0; i < tcis_pkg::REG_COUNT; i++)
            cpu_regs[i] = '0;
        for (int i = 0; i < tcis_pkg::MEM_WORDS; i++)
            cpu_mem[i] = '0;
        for (int i = 0; i < 23; i++)
            op_seen[i] = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        z = '0;
        add_row(tcis_pkg::FN_RD_REG, 8'd7, 32'hffff_ffff, 1'b1, z);
        add_row(tcis_pkg::FN_RD_REG, 8'd200, 32'd0, 1'b1, z);
        add_row(tcis_pkg::FN_RD_MEM, 8'd255, 32'd0, 1'b1, z);
        add_row(tcis_pkg::FN_LOAD, 8'd255, 32'h8000_0000, 1'b1, z);
        add_row(tcis_pkg::FN_RD_MEM, 8'd255, 32'd0, 1'b1,
                '{tcis_pkg::ST_RUN, 32'd0, 1'b0, 32'h8000_0000});
        add_row(tcis_pkg::FN_LOAD, 8'd12, 32'h7fff_ffff, 1'b0, z);
        add_row(tcis_pkg::FN_LOAD, 8'd13, 32'h8000_0000, 1'b0, z);
        add_row(tcis_pkg::FN_LOAD, 8'd14, 32'hffff_ffff, 1'b0, z);
        add_row(tcis_pkg::FN_LOAD, 8'd0, instr(tcis_pkg::OP_LW, 2'd0, 2'd1, 4'd12), 1'b0, z);
        add_row(tcis_pkg::FN_EXEC, 8'd0, 32'd0, 1'b1, '{tcis_pkg::ST_RUN, 32'd1, 1'b0, 32'd0});
        add_row(tcis_pkg::FN_LOAD, 8'd1, instr(tcis_pkg::OP_LW, 2'd0, 2'd2, 4'd13), 1'b0, z);
        add_row(tcis_pkg::FN_EXEC, 8'd0, 32'd0, 1'b0, z);
        add_row(tcis_pkg::FN_LOAD, 8'd2, instr(tcis_pkg::OP_LW, 2'd0, 2'd3, 4'd14), 1'b0, z);
        add_row(tcis_pkg::FN_EXEC, 8'd0, 32'd0, 1'b0, z);
        // most negative over minus one, then swap
        add_row(tcis_pkg::FN_LOAD, 8'd3, instr(tcis_pkg::OP_XIDIV, 2'd2, 2'd3, 4'd5), 1'b0, z);
        add_row(tcis_pkg::FN_EXEC, 8'd0, 32'd0, 1'b0, z);
        add_row(tcis_pkg::FN_RD_REG, 8'd5, 32'd0, 1'b1,
                '{tcis_pkg::ST_RUN, 32'd4, 1'b0, 32'h8000_0000});
        add_row(tcis_pkg::FN_LOAD, 8'd4, instr(tcis_pkg::OP_ADD, 2'd1, 2'd1, 4'd4), 1'b0, z);
        add_row(tcis_pkg::FN_EXEC, 8'd0, 32'd0, 1'b0, z);
        // huge rotate count
        add_row(tcis_pkg::FN_LOAD, 8'd5, instr(tcis_pkg::OP_RCR, 2'd3, 2'd1, 4'd6), 1'b0, z);
        add_row(tcis_pkg::FN_EXEC, 8'd0, 32'd0, 1'b0, z);
        add_row(tcis_pkg::FN_LOAD, 8'd6, instr(tcis_pkg::OP_BT, 2'd2, 2'd3, 4'd0), 1'b0, z);
        add_row(tcis_pkg::FN_EXEC, 8'd0, 32'd0, 1'b0, z);
        add_row(tcis_pkg::FN_LOAD, 8'd7, instr(tcis_pkg::OP_JALR, 2'd0, 2'd1, 4'd0), 1'b0, z);
        add_row(tcis_pkg::FN_EXEC, 8'd0, 32'd0, 1'b0, z);
        add_row(tcis_pkg::FN_RD_REG, 8'd1, 32'd0, 1'b1, '{tcis_pkg::ST_RUN, 32'd0, 1'b1, 32'd8});
        foreach (rows[i])
            send_item(rows[i].func, rows[i].address, rows[i].data, rows[i].lit_en, rows[i].lit);

        for (int i = 0; i < RAND_ITEMS; )
        begin
            if (i >= 400 && !hold_done)
            begin
                hold_done = 1'b1;
                rsp_hold = 300;
            end
            if (i >= 800 && !pause_done)
            begin
                pause_done = 1'b1;
                req_ch.valid = 1'b0;
                while (pending_q.size() != 0)
                    @(negedge clk);
            end
            if (i > 1200)
                idle_on = 1'b0;
            k = $urandom_range(0, 9);
            if (k < 6)
            begin
                exec_word(safe_instr());
                i += 2;
            end
            else if (k < 8)
            begin
                send(tcis_pkg::FN_LOAD, 8'($urandom), rand_word());
                i++;
            end
            else
            begin
                send(k == 8 ? tcis_pkg::FN_RD_REG : tcis_pkg::FN_RD_MEM, 8'($urandom),
                     $urandom);
                i++;
            end
        end

        // stop the machine one way, then prove nothing executes afterwards
        case ($urandom_range(0, 4))
            0: exec_word(instr(tcis_pkg::OP_HALT, 2'($urandom), 2'($urandom), 4'($urandom)));
            1: exec_word(instr(tcis_pkg::OP_W'($urandom_range(23, 24'hffffff)), 2'($urandom),
                               2'($urandom), 4'($urandom)));
            2: exec_word(instr(tcis_pkg::OP_DIV, 2'($urandom), 2'd0, 4'($urandom)));
            3:
            begin
                send(tcis_pkg::FN_LOAD, 8'd15, 32'h7fff_fff0 | $urandom_range(0, 15));
                exec_word(instr(tcis_pkg::OP_LW, 2'd0, 2'd1, 4'd15));
                exec_word(instr($urandom_range(0, 1) ? tcis_pkg::OP_LW : tcis_pkg::OP_SW,
                                2'd1, 2'($urandom), 4'($urandom)));
            end
            default:
            begin
                send(tcis_pkg::FN_LOAD, 8'd15, 32'd256 + $urandom_range(0, 1000));
                exec_word(instr(tcis_pkg::OP_LW, 2'd0, 2'd2, 4'd15));
                exec_word(instr(tcis_pkg::OP_JALR, 2'd2, 2'd3, 4'd0));
                exec_word(instr(tcis_pkg::OP_NOOP, 2'd0, 2'd0, 4'd0));
            end
        endcase
        for (int i = 0; i < 6; i++)
        begin
            w = safe_instr();
            send(tcis_pkg::FN_EXEC, 8'($urandom), w);
            send(tcis_pkg::FN_RD_REG, 8'($urandom_range(0, 7)), 32'd0);
        end
        req_ch.valid = 1'b0;
        stim_done = 1'b1;

        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);

        k = 0;
        foreach (op_seen[i])
            if (op_seen[i] != 0)
                k++;
        $display("tb: %0d items, %0d instructions, %0d of 23 opcodes run, final status %0d",
                 n_items, n_exec, k, cpu_status);
        if (n_mismatch == 0 && pending_q.size() == 0)
            $display("tb: success");
        else
        begin
            $display("tb: %0d mismatches, %0d beats missing", n_mismatch, pending_q.size());
            $display("tb: failure");
        end
        $finish;
    end
endmodule
